[hw/rtl/dmpl_pkg.sv]
`default_nettype none
package dmpl_pkg;

    localparam int TW = 16;
    localparam int LW = 15;
    localparam int PW = 32;
    localparam int GW = 24;
    localparam int IW = 2;

    // register indexes
    localparam logic [IW-1:0] REG_BIAS   = 2'd0;
    localparam logic [IW-1:0] REG_COPPER = 2'd1;
    localparam logic [IW-1:0] REG_MECH   = 2'd2;

    // estimator register stages and divider steps (quotient below 2^15)
    localparam int EST_LAT   = 4;
    localparam int DIV_STEPS = 15;

    localparam int S_CHK   = EST_LAT + 1;
    localparam int S_FIN   = S_CHK + DIV_STEPS + 1;
    localparam int S_LAST  = S_FIN + EST_LAT;
    localparam int NSTG    = S_LAST + 1;

    typedef struct packed {
        logic                  rv;
        logic                  cpos;
        logic                  over;
        logic signed [PW-1:0]  cap;
        logic signed [TW-1:0]  tl;
        logic signed [TW-1:0]  tr;
        logic signed [TW-1:0]  vl;
        logic signed [TW-1:0]  vr;
        logic signed [PW-1:0]  est1;
    } item_t;

    typedef struct packed {
        logic [PW-1:0]        rem_l;
        logic [DIV_STEPS-1:0] nq_l;
        logic [PW-1:0]        rem_r;
        logic [DIV_STEPS-1:0] nq_r;
    } div_t;

endpackage
`default_nettype wire

[hw/rtl/dmpl_est.sv]
`default_nettype none
module dmpl_est (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic signed [dmpl_pkg::TW-1:0]  tl,
    input  wire logic signed [dmpl_pkg::TW-1:0]  tr,
    input  wire logic signed [dmpl_pkg::TW-1:0]  vl,
    input  wire logic signed [dmpl_pkg::TW-1:0]  vr,
    input  wire logic signed [dmpl_pkg::PW-1:0]  bias,
    input  wire logic [dmpl_pkg::GW-1:0]         cgain,
    input  wire logic [dmpl_pkg::GW-1:0]         mgain,
    output logic signed [dmpl_pkg::PW-1:0]       est
);
    import dmpl_pkg::*;

    logic signed [31:0] sql_reg, sqr_reg, ml_reg, mr_reg;
    logic [31:0]        sq_reg, mech_reg;
    logic [55:0]        pc_reg, pm_reg;
    logic signed [PW-1:0] est_reg, est_next;
    logic signed [31:0] abs_l, abs_r;
    logic signed [63:0] total, rnd;
    logic signed [39:0] q;

    always_comb
    begin
        abs_l = ml_reg[31] ? -ml_reg : ml_reg;
        abs_r = mr_reg[31] ? -mr_reg : mr_reg;
        total = ({{8{bias[PW-1]}}, bias, 24'd0})
              + $signed({8'd0, pc_reg})
              + $signed({4'd0, pm_reg, 4'd0});
        rnd   = total + 64'sd8388608;
        q     = rnd[63:24];
        if (q > 40'sh007fffffff)
            est_next = 32'sh7fffffff;
        else if (q < -40'sh0080000000)
            est_next = 32'sh80000000;
        else
            est_next = q[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            sql_reg  <= tl * tl;
            sqr_reg  <= tr * tr;
            ml_reg   <= tl * vl;
            mr_reg   <= tr * vr;
            // sums
            sq_reg   <= sql_reg + sqr_reg;
            mech_reg <= abs_l + abs_r;
            // gains
            pc_reg   <= cgain * sq_reg;
            pm_reg   <= mgain * mech_reg;
            // bias, round, saturate
            est_reg  <= est_next;
        end
    end

    assign est = est_reg;

endmodule
`default_nettype wire

[hw/rtl/dual_motor_power_limiter_core.sv]
`default_nettype none
// Two-motor torque limiter. Each request is clamped to its per-motor torque
// limit, its power is estimated as bias + copper*(tl^2+tr^2) + mech*(|tl*vl|+
// |tr*vr|) in Q16.16 with rounding and saturation, and if that exceeds a
// positive power cap both torques are scaled by cap/estimate (magnitude
// truncated) and the power is estimated again. A cap of zero or below gives
// zero torque; an invalid request gives zero outputs with drive_valid low.
// The datapath is a pipeline (input stage, four-stage estimator,
// check stage, 15 one-bit divider stages, scale stage, second estimator,
// output register) that takes one request every cycle; the whole pipe halts
// only while a finished result is stalled at the output. Configuration writes
// are always ready and take effect at once, so write them while idle.
module dual_motor_power_limiter_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [dmpl_pkg::TW-1:0]  left_request,
    input  wire logic signed [dmpl_pkg::TW-1:0]  right_request,
    input  wire logic                            request_valid,
    input  wire logic signed [dmpl_pkg::TW-1:0]  left_speed,
    input  wire logic signed [dmpl_pkg::TW-1:0]  right_speed,
    input  wire logic [dmpl_pkg::LW-1:0]         left_limit,
    input  wire logic [dmpl_pkg::LW-1:0]         right_limit,
    input  wire logic signed [dmpl_pkg::PW-1:0]  power_cap,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [dmpl_pkg::TW-1:0]       left_drive,
    output logic signed [dmpl_pkg::TW-1:0]       right_drive,
    output logic                                 drive_valid,
    output logic signed [dmpl_pkg::PW-1:0]       power_estimate,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dmpl_pkg::IW-1:0]         cfg_index,
    input  wire logic [dmpl_pkg::PW-1:0]         cfg_data
);
    import dmpl_pkg::*;

    // configuration registers
    logic signed [PW-1:0] bias_reg;
    logic [GW-1:0]        copper_reg;
    logic [GW-1:0]        mech_reg;

    // pipeline
    item_t pipe_reg  [NSTG];
    item_t pipe_next [NSTG];
    div_t  div_reg   [DIV_STEPS+1];
    div_t  div_next  [DIV_STEPS+1];

    logic adv;
    logic signed [PW-1:0] est1, est2;

    // output register
    logic                 out_valid_reg;
    logic signed [TW-1:0] ld_reg, rd_reg;
    logic                 dv_reg;
    logic signed [PW-1:0] pe_reg;

    // valid bit per stage
    logic [NSTG-1:0] vld_reg;

    // clamp helpers
    logic signed [TW:0] lreq_x, rreq_x, llim_x, rlim_x;
    logic signed [TW-1:0] lcl, rcl;
    logic cpos_in, use_in;
    logic [45:0] num_l, num_r;
    logic [TW-2:0] mag_l, mag_r;

    // the whole pipe moves unless a held result is stalled
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg   <= '0;
            copper_reg <= '0;
            mech_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BIAS:   bias_reg   <= cfg_data;
                REG_COPPER: copper_reg <= cfg_data[GW-1:0];
                REG_MECH:   mech_reg   <= cfg_data[GW-1:0];
                default:    ;
            endcase
        end
    end

    // first estimate on clamped torques
    dmpl_est u_est1 (
        .clk   (clk),
        .en    (adv),
        .tl    (pipe_reg[0].tl),
        .tr    (pipe_reg[0].tr),
        .vl    (pipe_reg[0].vl),
        .vr    (pipe_reg[0].vr),
        .bias  (bias_reg),
        .cgain (copper_reg),
        .mgain (mech_reg),
        .est   (est1)
    );

    // second estimate on scaled torques
    dmpl_est u_est2 (
        .clk   (clk),
        .en    (adv),
        .tl    (pipe_reg[S_FIN].tl),
        .tr    (pipe_reg[S_FIN].tr),
        .vl    (pipe_reg[S_FIN].vl),
        .vr    (pipe_reg[S_FIN].vr),
        .bias  (bias_reg),
        .cgain (copper_reg),
        .mgain (mech_reg),
        .est   (est2)
    );

    always_comb
    begin
        // input stage: clamp, zero torque on bad request or non-positive cap
        lreq_x  = {left_request[TW-1], left_request};
        rreq_x  = {right_request[TW-1], right_request};
        llim_x  = {2'b00, left_limit};
        rlim_x  = {2'b00, right_limit};
        cpos_in = !power_cap[PW-1] && (power_cap != '0);
        use_in  = request_valid && cpos_in;

        if (lreq_x > llim_x)
            lcl = llim_x[TW-1:0];
        else if (lreq_x < -llim_x)
            lcl = TW'(-llim_x);
        else
            lcl = left_request;

        if (rreq_x > rlim_x)
            rcl = rlim_x[TW-1:0];
        else if (rreq_x < -rlim_x)
            rcl = TW'(-rlim_x);
        else
            rcl = right_request;

        pipe_next[0].rv   = request_valid;
        pipe_next[0].cpos = cpos_in;
        pipe_next[0].over = 1'b0;
        pipe_next[0].cap  = power_cap;
        pipe_next[0].tl   = use_in ? lcl : '0;
        pipe_next[0].tr   = use_in ? rcl : '0;
        pipe_next[0].vl   = left_speed;
        pipe_next[0].vr   = right_speed;
        pipe_next[0].est1 = '0;

        for (int k = 1; k < NSTG; k++)
            pipe_next[k] = pipe_reg[k-1];

        // check stage: pick up first estimate, decide on scaling
        pipe_next[S_CHK].est1 = est1;
        pipe_next[S_CHK].over = pipe_reg[S_CHK-1].rv && pipe_reg[S_CHK-1].cpos
                              && (est1 > pipe_reg[S_CHK-1].cap);

        // numerators |t|*cap, divider seed (clamped torques fit in 15 bits)
        mag_l = pipe_reg[S_CHK-1].tl[TW-1] ? (TW-1)'(-pipe_reg[S_CHK-1].tl)
                                           : pipe_reg[S_CHK-1].tl[TW-2:0];
        mag_r = pipe_reg[S_CHK-1].tr[TW-1] ? (TW-1)'(-pipe_reg[S_CHK-1].tr)
                                           : pipe_reg[S_CHK-1].tr[TW-2:0];
        num_l = mag_l * pipe_reg[S_CHK-1].cap[PW-2:0];
        num_r = mag_r * pipe_reg[S_CHK-1].cap[PW-2:0];
        div_next[0].rem_l = {1'b0, num_l[45:DIV_STEPS]};
        div_next[0].nq_l  = num_l[DIV_STEPS-1:0];
        div_next[0].rem_r = {1'b0, num_r[45:DIV_STEPS]};
        div_next[0].nq_r  = num_r[DIV_STEPS-1:0];

        // one quotient bit per stage and lane
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            logic [PW:0] tl_w, tr_w, den;
            den  = {1'b0, pipe_reg[S_CHK+k-1].est1};
            tl_w = {div_reg[k-1].rem_l, div_reg[k-1].nq_l[DIV_STEPS-1]};
            tr_w = {div_reg[k-1].rem_r, div_reg[k-1].nq_r[DIV_STEPS-1]};
            if (tl_w >= den)
            begin
                div_next[k].rem_l = PW'(tl_w - den);
                div_next[k].nq_l  = {div_reg[k-1].nq_l[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem_l = tl_w[PW-1:0];
                div_next[k].nq_l  = {div_reg[k-1].nq_l[DIV_STEPS-2:0], 1'b0};
            end
            if (tr_w >= den)
            begin
                div_next[k].rem_r = PW'(tr_w - den);
                div_next[k].nq_r  = {div_reg[k-1].nq_r[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem_r = tr_w[PW-1:0];
                div_next[k].nq_r  = {div_reg[k-1].nq_r[DIV_STEPS-2:0], 1'b0};
            end
        end

        // scale stage: signed quotient replaces torque when over the cap
        if (pipe_reg[S_FIN-1].over)
        begin
            pipe_next[S_FIN].tl = pipe_reg[S_FIN-1].tl[TW-1]
                                ? -$signed({1'b0, div_reg[DIV_STEPS].nq_l})
                                :  $signed({1'b0, div_reg[DIV_STEPS].nq_l});
            pipe_next[S_FIN].tr = pipe_reg[S_FIN-1].tr[TW-1]
                                ? -$signed({1'b0, div_reg[DIV_STEPS].nq_r})
                                :  $signed({1'b0, div_reg[DIV_STEPS].nq_r});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NSTG-2:0], in_valid};
            out_valid_reg <= vld_reg[S_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
                pipe_reg[k] <= pipe_next[k];
            for (int k = 0; k <= DIV_STEPS; k++)
                div_reg[k] <= div_next[k];
            // result: invalid request reports zero, else the latest estimate
            ld_reg <= pipe_reg[S_LAST].tl;
            rd_reg <= pipe_reg[S_LAST].tr;
            dv_reg <= pipe_reg[S_LAST].rv;
            if (!pipe_reg[S_LAST].rv)
                pe_reg <= '0;
            else if (pipe_reg[S_LAST].over)
                pe_reg <= est2;
            else
                pe_reg <= pipe_reg[S_LAST].est1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_drive     = ld_reg;
    assign right_drive    = rd_reg;
    assign drive_valid    = dv_reg;
    assign power_estimate = pe_reg;

`ifndef NO_ASSERTIONS
    // an invalid request leaves nothing but zeros
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_valid) |->
        (left_drive == '0 && right_drive == '0 && power_estimate == '0))
        else $error("invalid request produced nonzero result");

    // scaling only when the first estimate exceeds a positive cap
    a_over_cond: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_CHK] && pipe_reg[S_CHK].over) |->
        (pipe_reg[S_CHK].cap > 0 && pipe_reg[S_CHK].est1 > pipe_reg[S_CHK].cap))
        else $error("scaling flagged without overrun");

    // a stalled result freezes the valid bit of every stage
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire

[bench/dual_motor_power_limiter_core_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module dual_motor_power_limiter_core_tb;
    import dmpl_pkg::*;

    // index with no register behind it
    localparam logic [IW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [TW-1:0] lreq;
        logic signed [TW-1:0] rreq;
        logic                 rvalid;
        logic signed [TW-1:0] lspd;
        logic signed [TW-1:0] rspd;
        logic [LW-1:0]        llim;
        logic [LW-1:0]        rlim;
        logic signed [PW-1:0] cap;
    } request_t;

    typedef struct packed {
        logic signed [TW-1:0] ldrv;
        logic signed [TW-1:0] rdrv;
        logic                 dvalid;
        logic signed [PW-1:0] pest;
    } drive_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [TW-1:0] left_request;
    logic signed [TW-1:0] right_request;
    logic request_valid;
    logic signed [TW-1:0] left_speed;
    logic signed [TW-1:0] right_speed;
    logic [LW-1:0] left_limit;
    logic [LW-1:0] right_limit;
    logic signed [PW-1:0] power_cap;
    logic out_valid;
    logic out_stall;
    logic signed [TW-1:0] left_drive;
    logic signed [TW-1:0] right_drive;
    logic drive_valid;
    logic signed [PW-1:0] power_estimate;
    logic cfg_valid;
    logic cfg_ready;
    logic [IW-1:0] cfg_index;
    logic [PW-1:0] cfg_data;

    dual_motor_power_limiter_core dut (.*);

    // predictor copy of the gain registers
    logic signed [31:0] bias_q;
    logic [23:0] copper_q;
    logic [23:0] mech_q;

    request_t pending_reqs[$];
    drive_t   expected_drives[$];
    int errors = 0;
    int n_checked = 0;
    int n_scaled = 0;
    int n_capped = 0;
    bit stim_done;
    bit hold_active;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] mag(input logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // power estimate of a torque pair, rounded half up and saturated to q16.16
    function automatic logic signed [31:0] power_of(input logic signed [31:0] tl,
        input logic signed [31:0] tr, input logic signed [31:0] vl,
        input logic signed [31:0] vr);
        logic signed [63:0] sq;
        logic signed [63:0] mw;
        logic signed [63:0] total;
        logic signed [63:0] q;
        sq = 64'(tl) * tl + 64'(tr) * tr;
        mw = mag(64'(tl) * vl) + mag(64'(tr) * vr);
        total = 64'(bias_q) * 64'sd16777216 + $signed({40'd0, copper_q}) * sq
              + $signed({40'd0, mech_q}) * mw * 16;
        q = (total + 64'sd8388608) >>> 24;  // arithmetic shift is floor division
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_torque(input logic signed [31:0] t,
        input logic signed [31:0] lim);
        if (t > lim)
            return lim;
        if (t < -lim)
            return -lim;
        return t;
    endfunction

    function automatic logic signed [31:0] scale_torque(input logic signed [31:0] t,
        input logic signed [31:0] cap, input logic signed [31:0] est);
        logic signed [63:0] m;
        m = mag(64'(t)) * 64'(cap) / 64'(est);
        return t < 0 ? -m[31:0] : m[31:0];
    endfunction

    function automatic drive_t limit_drive(input request_t r);
        drive_t d;
        logic signed [31:0] tl;
        logic signed [31:0] tr;
        logic signed [31:0] est;
        tl = 0;
        tr = 0;
        est = 0;
        if (r.rvalid)
        begin
            if (r.cap <= 0)
            begin
                est = power_of(0, 0, r.lspd, r.rspd);
                n_capped++;
            end
            else
            begin
                tl = clamp_torque(r.lreq, $signed({17'd0, r.llim}));
                tr = clamp_torque(r.rreq, $signed({17'd0, r.rlim}));
                est = power_of(tl, tr, r.lspd, r.rspd);
                if (est > r.cap)
                begin
                    tl = scale_torque(tl, r.cap, est);
                    tr = scale_torque(tr, r.cap, est);
                    est = power_of(tl, tr, r.lspd, r.rspd);
                    n_scaled++;
                end
            end
        end
        d.ldrv = tl[15:0];
        d.rdrv = tr[15:0];
        d.dvalid = r.rvalid;
        d.pest = est;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
        input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver: bursts of requests with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {left_request, right_request, request_valid, left_speed, right_speed,
             left_limit, right_limit, power_cap} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_drives.push_back(limit_drive(pending_reqs.pop_front()));
            if (in_valid && in_stall)
            begin
                // hold the stalled request steady
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_valid <= 1'b1;
                {left_request, right_request, request_valid, left_speed, right_speed,
                 left_limit, right_limit, power_cap} <= pending_reqs[0];
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, plus a long hold-off when requested
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 2);
            if (hold_active)
                out_stall <= 1'b1;
            else if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drives.size() == 0)
            begin
                $display("unexpected result at %0t", $time);
                errors++;
            end
            else
            begin
                want = expected_drives.pop_front();
                n_checked++;
                if (drive_valid !== want.dvalid)
                    report_mismatch("drive_valid", drive_valid, want.dvalid);
                if (left_drive !== want.ldrv)
                    report_mismatch("left_drive", left_drive, want.ldrv);
                if (right_drive !== want.rdrv)
                    report_mismatch("right_drive", right_drive, want.rdrv);
                if (power_estimate !== want.pest)
                    report_mismatch("power_estimate", power_estimate, want.pest);
            end
        end
    end

    task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BIAS:   bias_q = val;
            REG_COPPER: copper_q = val[23:0];
            REG_MECH:   mech_q = val[23:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_gains(input logic [31:0] b, input logic [23:0] c,
        input logic [23:0] m);
        write_reg(REG_BIAS, b);
        write_reg(REG_COPPER, {8'd0, c});
        write_reg(REG_MECH, {8'd0, m});
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_drives.size() > 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    function automatic request_t make_req(input int lr, input int rr,
        input bit v, input int ls, input int rs, input int ll, input int rl,
        input int cp);
        request_t r;
        r.lreq = TW'(lr);
        r.rreq = TW'(rr);
        r.rvalid = v;
        r.lspd = TW'(ls);
        r.rspd = TW'(rs);
        r.llim = LW'(ll);
        r.rlim = LW'(rl);
        r.cap = cp;
        return r;
    endfunction

    // random request; mostly valid with a positive cap so the scaling path runs
    function automatic request_t rand_req();
        request_t r;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(request_t)-1:0];
        r.rvalid = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0: r.cap = -$signed($urandom_range(0, 1000));
            1: r.cap = $urandom;
            2, 3, 4: r.cap = $urandom_range(1, 32'h0100_0000);
            default: r.cap = $urandom_range(1, 32'h0040_0000);
        endcase
        if ($urandom_range(0, 3) == 0)
            r.llim = 15'h7fff;
        if ($urandom_range(0, 3) == 0)
            r.rlim = LW'($urandom_range(0, 15));
        return r;
    endfunction

    task automatic run_random(input int n);
        repeat (n)
            pending_reqs.push_back(rand_req());
    endtask

    // long receiver hold-off while the sender keeps offering requests
    initial
    begin
        hold_active = 1'b0;
        wait (stim_done === 1'b0 && n_checked > 300);
        hold_active = 1'b1;
        repeat (200)
            @(posedge clk);
        hold_active = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        bias_q = 0;
        copper_q = 0;
        mech_q = 0;
        stim_done = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: estimate is zero, torques pass clamped
        pending_reqs.push_back(make_req(1000, -1000, 1, 100, -100, 500, 2000, 10));
        wait_idle();

        // moderate gains, directed corners
        set_gains(32'h0001_0000, 24'h01_0000, 24'h00_8000);
        pending_reqs.push_back(make_req(32767, -32768, 1, 32767, -32768,
                                        32767, 32767, 32'h7fff_ffff));
        pending_reqs.push_back(make_req(32767, -32768, 1, 32767, -32768, 0, 0, 100));
        pending_reqs.push_back(make_req(5000, 5000, 0, 10, 10, 9000, 9000, 1000));
        pending_reqs.push_back(make_req(5000, 5000, 1, 10, 10, 9000, 9000, 0));
        pending_reqs.push_back(make_req(5000, 5000, 1, 10, 10, 9000, 9000,
                                        32'h8000_0000));
        pending_reqs.push_back(make_req(-20000, 20000, 1, -500, 500, 8000, 30000,
                                        32'h0000_8000));
        pending_reqs.push_back(make_req(4096, -4096, 1, 256, 256, 32767, 32767, 1));
        pending_reqs.push_back(make_req(100, 100, 1, 0, 0, 32767, 32767,
                                        32'h7fff_ffff));
        wait_idle();

        // large bias: still above cap after scaling
        set_gains(32'h7fff_ffff, 24'hff_ffff, 24'hff_ffff);
        pending_reqs.push_back(make_req(32767, 32767, 1, 32767, 32767,
                                        32767, 32767, 1000));
        pending_reqs.push_back(make_req(-32768, -32768, 1, -32768, -32768,
                                        32767, 32767, 32'h7fff_ffff));
        pending_reqs.push_back(make_req(1, 1, 1, 1, 1, 32767, 32767, -1));
        run_random(450);
        wait_idle();

        set_gains(32'h8000_0000, 24'h00_0000, 24'hff_ffff);
        pending_reqs.push_back(make_req(100, -100, 1, 3, 3, 32767, 32767, 0));
        run_random(450);
        wait_idle();

        set_gains(32'hffff_0000, 24'h00_4000, 24'h00_0100);
        write_reg(REG_SPARE, 32'hdead_beef);  // unused index is ignored
        run_random(500);
        wait_idle();

        set_gains($urandom, 24'($urandom), 24'($urandom));
        run_random(480);
        wait_idle();

        stim_done = 1'b1;
        repeat (2 * NSTG)
            @(posedge clk);
        $display("checked %0d results: %0d rescaled, %0d with cap at or below zero",
                 n_checked, n_scaled, n_capped);
        $display("gain settings covered reset, extremes and random values");
        if (errors == 0 && expected_drives.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
